// ----- hdl/urm5_pkg.sv -----
// ----------------------------------------------------------------------------
// urm5_pkg
// Shared types and constants for the ultrasonic ranger with median filter.
// ----------------------------------------------------------------------------
package urm5_pkg;

  localparam int ELAPSED_W = 26;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 26'h3FF_FFFF;

  localparam int US_W = 20;
  localparam int MM_W = 18;
  localparam logic [MM_W-1:0] MM_MAX = 18'h3FFFF;
  localparam int MM_SCALE_W = 7;
  localparam logic [MM_SCALE_W-1:0] MM_SCALE = 7'd100;

  localparam int FACTOR_W = 10;
  localparam int TIMEOUT_W = 10;
  localparam int DELAY_W = 16;
  localparam int OP_W = 2;
  localparam int PULSE_W = 5;

  localparam int RING_LEN = 5;
  localparam int RING_IDX_W = 3;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 10'd583;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 10'd100;

  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_DELAY = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_WAIT  = 2'd3
  } mode_t;

  typedef struct packed {
    logic  trigger;
    mode_t status;
    logic  measured;
    logic  timed_out;
  } ctl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_SEL,
    B_START,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ----- hdl/urm5_intf.sv -----
// ----------------------------------------------------------------------------
// urm5 channel interfaces
// Tick request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface urm5_tick_if;
  logic                        valid;
  logic                        ready;
  logic [urm5_pkg::OP_W-1:0]    operation;
  logic [urm5_pkg::DELAY_W-1:0] start_delay_ms;
  logic                        echo_level;

  modport source(output valid, operation, start_delay_ms, echo_level, input ready);
  modport sink(input valid, operation, start_delay_ms, echo_level, output ready);
endinterface

interface urm5_result_if;
  logic                     valid;
  logic                     ready;
  logic                     trigger_level;
  logic [1:0]               status;
  logic                     measure_event;
  logic                     timeout_event;
  logic [urm5_pkg::US_W-1:0] raw_us;
  logic [urm5_pkg::MM_W-1:0] raw_mm;
  logic [urm5_pkg::US_W-1:0] measure_us;
  logic [urm5_pkg::MM_W-1:0] measure_mm;
  logic [urm5_pkg::US_W-1:0] filtered_us;
  logic [urm5_pkg::MM_W-1:0] filtered_mm;

  modport source(output valid, trigger_level, status, measure_event, timeout_event,
                 raw_us, raw_mm, measure_us, measure_mm, filtered_us, filtered_mm,
                 input ready);
  modport sink(input valid, trigger_level, status, measure_event, timeout_event,
               raw_us, raw_mm, measure_us, measure_mm, filtered_us, filtered_mm,
               output ready);
endinterface

// ----- hdl/urm5_fifo.sv -----
// ----------------------------------------------------------------------------
// urm5_fifo
// Short register queue between the tick front end and the result back end.
// ----------------------------------------------------------------------------
module urm5_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/urm5_div.sv -----
// ----------------------------------------------------------------------------
// urm5_div
// Bit-serial restoring divider, one quotient bit per cycle, saturating result.
// ----------------------------------------------------------------------------
module urm5_div #(
  parameter int NUM_W = 27
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [urm5_pkg::FACTOR_W-1:0] den,
  output logic                          busy,
  output logic [urm5_pkg::MM_W-1:0]     quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int FW = urm5_pkg::FACTOR_W;

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [FW-1:0]    rem;
  logic [FW-1:0]    den_r;
  logic [FW:0]      rem_sh;
  logic [FW:0]      diff;
  logic             ge;

  assign rem_sh = {rem, acc[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});
  assign diff   = rem_sh - {1'b0, den_r};
  assign busy   = (cnt != '0);

  always_comb begin
    if (den_r == '0 || acc > NUM_W'(urm5_pkg::MM_MAX)) begin
      quo = urm5_pkg::MM_MAX;
    end else begin
      quo = acc[urm5_pkg::MM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= ge ? diff[FW-1:0] : rem_sh[FW-1:0];
    end
  end

endmodule

// ----- hdl/urm5_front.sv -----
// ----------------------------------------------------------------------------
// urm5_front
// Per-tick ranging sequencer: start delay, trigger pulse, echo timing, timeout.
// ----------------------------------------------------------------------------
module urm5_front #(
  parameter int TIME_WIDTH         = 20,
  parameter int TICKS_PER_MS       = 1000,
  parameter int TRIGGER_HIGH_TICKS = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  urm5_tick_if.sink                      tick,
  input  logic [urm5_pkg::TIMEOUT_W-1:0] timeout_ms,
  input  logic                           q_full,
  output logic                           q_push,
  output urm5_pkg::ctl_t                 q_ctl,
  output logic [TIME_WIDTH-1:0]          q_width
);

  localparam int EW = urm5_pkg::ELAPSED_W;
  localparam int TPM_W = $clog2(TICKS_PER_MS + 1);
  localparam logic [TPM_W-1:0] TPM = TPM_W'(TICKS_PER_MS);
  localparam int DLY_PW = (urm5_pkg::DELAY_W + TPM_W > EW) ? urm5_pkg::DELAY_W + TPM_W : EW;
  localparam int TMO_PW = (urm5_pkg::TIMEOUT_W + TPM_W > EW) ?
                          urm5_pkg::TIMEOUT_W + TPM_W : EW;
  localparam logic [urm5_pkg::PULSE_W-1:0] PULSE_LEN =
    urm5_pkg::PULSE_W'(TRIGGER_HIGH_TICKS);
  localparam logic [TIME_WIDTH-1:0] WIDTH_MAX = '1;

  urm5_pkg::mode_t              mode, mode_next;
  logic [EW-1:0]                elapsed, elapsed_next;
  logic [EW-1:0]                delay_tgt, delay_tgt_next;
  logic [EW-1:0]                timeout_tgt;
  logic [urm5_pkg::PULSE_W-1:0] pulse_cnt, pulse_cnt_next;
  logic                         echo_seen, echo_seen_next;
  logic [TIME_WIDTH-1:0]        echo_width, echo_width_next;
  logic                         prior_echo;

  logic [DLY_PW-1:0] dly_prod;
  logic [TMO_PW-1:0] tmo_prod;
  logic [EW-1:0]     dly_ticks;
  logic              push;
  logic              fresh;
  logic              was_wait;
  logic              trig;
  logic              done;
  logic              tmo;

  assign tick.ready = !q_full;
  assign push       = tick.valid && tick.ready;

  assign dly_prod  = DLY_PW'(tick.start_delay_ms) * DLY_PW'(TPM);
  assign dly_ticks = (dly_prod > DLY_PW'(urm5_pkg::ELAPSED_MAX)) ?
                     urm5_pkg::ELAPSED_MAX : dly_prod[EW-1:0];
  assign tmo_prod  = TMO_PW'(timeout_ms) * TMO_PW'(TPM);
  assign timeout_tgt = (tmo_prod > TMO_PW'(urm5_pkg::ELAPSED_MAX)) ?
                       urm5_pkg::ELAPSED_MAX : tmo_prod[EW-1:0];

  always_comb begin
    mode_next       = mode;
    elapsed_next    = elapsed;
    delay_tgt_next  = delay_tgt;
    pulse_cnt_next  = pulse_cnt;
    echo_seen_next  = echo_seen;
    echo_width_next = echo_width;
    fresh           = 1'b0;
    trig            = 1'b0;
    done            = 1'b0;
    tmo             = 1'b0;

    if (tick.operation == urm5_pkg::OP_STOP) begin
      mode_next = urm5_pkg::MODE_IDLE;
    end else if (tick.operation == urm5_pkg::OP_START) begin
      mode_next      = urm5_pkg::MODE_DELAY;
      delay_tgt_next = dly_ticks;
      elapsed_next   = '0;
      fresh          = 1'b1;
    end

    was_wait = (mode_next == urm5_pkg::MODE_WAIT);

    if (mode_next == urm5_pkg::MODE_DELAY) begin
      if (!fresh && elapsed_next != urm5_pkg::ELAPSED_MAX) begin
        elapsed_next = elapsed_next + 1'b1;
      end
      if (elapsed_next >= delay_tgt_next) begin
        mode_next      = urm5_pkg::MODE_PULSE;
        pulse_cnt_next = '0;
      end
    end

    if (mode_next == urm5_pkg::MODE_PULSE) begin
      trig           = 1'b1;
      pulse_cnt_next = pulse_cnt_next + 1'b1;
      if (pulse_cnt_next >= PULSE_LEN) begin
        mode_next       = urm5_pkg::MODE_WAIT;
        elapsed_next    = '0;
        echo_seen_next  = 1'b0;
        echo_width_next = '0;
      end
    end else if (was_wait) begin
      if (elapsed_next != urm5_pkg::ELAPSED_MAX) begin
        elapsed_next = elapsed_next + 1'b1;
      end
      if (echo_seen) begin
        if (tick.echo_level) begin
          if (echo_width != WIDTH_MAX) begin
            echo_width_next = echo_width + 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end else if (tick.echo_level && !prior_echo) begin
        echo_seen_next  = 1'b1;
        echo_width_next = TIME_WIDTH'(1);
      end
      if (done) begin
        echo_seen_next = 1'b0;
        mode_next      = urm5_pkg::MODE_IDLE;
      end else if (elapsed_next >= timeout_tgt) begin
        tmo            = 1'b1;
        echo_seen_next = 1'b0;
        mode_next      = urm5_pkg::MODE_IDLE;
      end
    end
  end

  always_comb begin
    q_push          = push;
    q_ctl.trigger   = trig;
    q_ctl.status    = mode_next;
    q_ctl.measured  = done;
    q_ctl.timed_out = tmo;
    q_width         = echo_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= urm5_pkg::MODE_IDLE;
      elapsed     <= '0;
      delay_tgt   <= '0;
      pulse_cnt   <= '0;
      echo_seen   <= 1'b0;
      echo_width  <= '0;
      prior_echo  <= 1'b0;
    end else begin
      if (push) begin
        mode       <= mode_next;
        elapsed    <= elapsed_next;
        delay_tgt  <= delay_tgt_next;
        pulse_cnt  <= pulse_cnt_next;
        echo_seen  <= echo_seen_next;
        echo_width <= echo_width_next;
        prior_echo <= tick.echo_level;
      end
    end
  end

endmodule

// ----- hdl/urm5_back.sv -----
// ----------------------------------------------------------------------------
// urm5_back
// Measurement history, median of five and millimetre conversion per request.
// ----------------------------------------------------------------------------
module urm5_back #(
  parameter int TIME_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  urm5_pkg::ctl_t                q_ctl,
  input  logic [TIME_WIDTH-1:0]         q_width,
  output logic                          q_pop,
  input  logic [urm5_pkg::FACTOR_W-1:0] factor,
  urm5_result_if.source                 result
);

  localparam int RL = urm5_pkg::RING_LEN;
  localparam int NUM_W = TIME_WIDTH + urm5_pkg::MM_SCALE_W;
  localparam int EXT_W = (TIME_WIDTH > urm5_pkg::US_W) ? TIME_WIDTH : urm5_pkg::US_W;
  localparam logic [urm5_pkg::RING_IDX_W-1:0] RING_LAST = urm5_pkg::RING_IDX_W'(RL - 1);

  urm5_pkg::back_state_t state, state_next;
  urm5_pkg::ctl_t        ctl;

  logic [TIME_WIDTH-1:0]           last_raw;
  logic [TIME_WIDTH-1:0]           last_measure;
  logic [TIME_WIDTH-1:0]           ring [RL];
  logic [urm5_pkg::RING_IDX_W-1:0] ring_idx;
  logic [RL-1:0][RL-1:0]           lt;
  logic [2:0]                      less_cnt [RL];
  logic [2:0]                      greater_cnt [RL];
  logic [TIME_WIDTH-1:0]           med;
  logic [TIME_WIDTH-1:0]           filt;
  logic                            div_start;
  logic [2:0]                      div_busy;
  logic [urm5_pkg::MM_W-1:0]       raw_mm, measure_mm, filt_mm;
  logic [EXT_W-1:0]                raw_ext, measure_ext, filt_ext;

  urm5_div #(.NUM_W(NUM_W)) u_div_raw (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUM_W'(last_raw) * NUM_W'(urm5_pkg::MM_SCALE)),
    .den(factor), .busy(div_busy[0]), .quo(raw_mm)
  );

  urm5_div #(.NUM_W(NUM_W)) u_div_measure (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUM_W'(last_measure) * NUM_W'(urm5_pkg::MM_SCALE)),
    .den(factor), .busy(div_busy[1]), .quo(measure_mm)
  );

  urm5_div #(.NUM_W(NUM_W)) u_div_filt (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NUM_W'(filt) * NUM_W'(urm5_pkg::MM_SCALE)),
    .den(factor), .busy(div_busy[2]), .quo(filt_mm)
  );

  // median: the entry with at most two smaller and at most two larger entries
  always_comb begin
    med = '0;
    for (int i = 0; i < RL; i++) begin
      less_cnt[i]    = '0;
      greater_cnt[i] = '0;
      for (int j = 0; j < RL; j++) begin
        less_cnt[i]    = less_cnt[i] + {2'b00, lt[j][i]};
        greater_cnt[i] = greater_cnt[i] + {2'b00, lt[i][j]};
      end
      if (less_cnt[i] <= 3'd2 && greater_cnt[i] <= 3'd2) begin
        med = ring[i];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      urm5_pkg::B_IDLE: begin
        if (q_valid) begin
          state_next = urm5_pkg::B_CMP;
        end
      end
      urm5_pkg::B_CMP:   state_next = urm5_pkg::B_SEL;
      urm5_pkg::B_SEL:   state_next = urm5_pkg::B_START;
      urm5_pkg::B_START: state_next = urm5_pkg::B_DIV;
      urm5_pkg::B_DIV: begin
        if (div_busy == '0) begin
          state_next = urm5_pkg::B_OUT;
        end
      end
      urm5_pkg::B_OUT: begin
        if (result.ready) begin
          state_next = urm5_pkg::B_IDLE;
        end
      end
      default: state_next = urm5_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    result.valid = 1'b0;
    case (state)
      urm5_pkg::B_IDLE:  q_pop = q_valid;
      urm5_pkg::B_START: div_start = 1'b1;
      urm5_pkg::B_OUT:   result.valid = 1'b1;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= urm5_pkg::B_IDLE;
      last_raw     <= '0;
      last_measure <= '0;
      ring_idx     <= '0;
      for (int i = 0; i < RL; i++) begin
        ring[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (q_pop && q_ctl.measured) begin
        last_raw <= q_width;
        if (q_width != '0) begin
          last_measure   <= q_width;
          ring[ring_idx] <= q_width;
          ring_idx       <= (ring_idx == RING_LAST) ? '0 : ring_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctl <= q_ctl;
    end
    if (state == urm5_pkg::B_CMP) begin
      for (int i = 0; i < RL; i++) begin
        for (int j = 0; j < RL; j++) begin
          lt[i][j] <= (ring[i] < ring[j]);
        end
      end
    end
    if (state == urm5_pkg::B_SEL) begin
      filt <= (med == '0) ? last_measure : med;
    end
  end

  assign raw_ext     = EXT_W'(last_raw);
  assign measure_ext = EXT_W'(last_measure);
  assign filt_ext    = EXT_W'(filt);

  assign result.trigger_level = ctl.trigger;
  assign result.status        = ctl.status;
  assign result.measure_event = ctl.measured;
  assign result.timeout_event = ctl.timed_out;
  assign result.raw_us        = raw_ext[urm5_pkg::US_W-1:0];
  assign result.raw_mm        = raw_mm;
  assign result.measure_us    = measure_ext[urm5_pkg::US_W-1:0];
  assign result.measure_mm    = measure_mm;
  assign result.filtered_us   = filt_ext[urm5_pkg::US_W-1:0];
  assign result.filtered_mm   = filt_mm;

endmodule

// ----- hdl/ultrasonic_ranger_median5_top.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_ranger_median5_top
// Ultrasonic ranger controller with five-entry median filter.
// ----------------------------------------------------------------------------
// Each request on tick is one microsecond of sensor time and returns exactly
// one result on result. The front end runs the ping sequence (start delay,
// trigger pulse, echo timing, timeout) and takes one request per cycle into a
// four-entry queue while that queue is not full. The back end takes one queued
// entry at a time: it updates the history, picks the median of five and
// converts three widths to millimetres with three bit-serial dividers running
// side by side, each working through TIME_WIDTH + 7 quotient bits before the
// result is offered. Configuration writes must go in only while no request is
// outstanding; the block itself does not enforce this.
module ultrasonic_ranger_median5_top #(
  parameter int TIME_WIDTH         = 20,
  parameter int TICKS_PER_MS       = 1000,
  parameter int TRIGGER_HIGH_TICKS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  urm5_tick_if.sink                       tick,
  urm5_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [urm5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urm5_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ENTRY_W = $bits(urm5_pkg::ctl_t) + TIME_WIDTH;

  logic [urm5_pkg::FACTOR_W-1:0]  factor;
  logic [urm5_pkg::TIMEOUT_W-1:0] timeout_ms;

  logic                  f_push;
  urm5_pkg::ctl_t        f_ctl;
  logic [TIME_WIDTH-1:0] f_width;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;
  logic [ENTRY_W-1:0]    q_rdata;
  urm5_pkg::ctl_t        b_ctl;
  logic [TIME_WIDTH-1:0] b_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor     <= urm5_pkg::FACTOR_RESET;
      timeout_ms <= urm5_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        urm5_pkg::CFG_FACTOR:  factor <= cfg_data[urm5_pkg::FACTOR_W-1:0];
        urm5_pkg::CFG_TIMEOUT: timeout_ms <= cfg_data[urm5_pkg::TIMEOUT_W-1:0];
        default: begin
          factor <= factor;
        end
      endcase
    end
  end

  urm5_front #(
    .TIME_WIDTH(TIME_WIDTH),
    .TICKS_PER_MS(TICKS_PER_MS),
    .TRIGGER_HIGH_TICKS(TRIGGER_HIGH_TICKS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .tick(tick),
    .timeout_ms(timeout_ms),
    .q_full(q_full),
    .q_push(f_push),
    .q_ctl(f_ctl),
    .q_width(f_width)
  );

  urm5_fifo #(
    .W(ENTRY_W),
    .DEPTH(urm5_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(f_push),
    .wdata({f_ctl, f_width}),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  assign b_ctl   = urm5_pkg::ctl_t'(q_rdata[ENTRY_W-1:TIME_WIDTH]);
  assign b_width = q_rdata[TIME_WIDTH-1:0];

  urm5_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_ctl(b_ctl),
    .q_width(b_width),
    .q_pop(q_pop),
    .factor(factor),
    .result(result)
  );

endmodule

// ----- bench/ultrasonic_ranger_median5_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_ranger_median5_checker
// Watches the tick and result channels and the register port. It keeps its
// own copy of the ranger state, works out the reading that each accepted tick
// request must produce, and compares every delivered reading field by field.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_median5_checker #(
  parameter int TIME_WIDTH         = 20,
  parameter int TICKS_PER_MS       = 1000,
  parameter int TRIGGER_HIGH_TICKS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  urm5_tick_if                            tick,
  urm5_result_if                          result,
  input  logic                            cfg_we,
  input  logic [urm5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urm5_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              in_flight,
  output int                              echoes_timed,
  output int                              timeouts_seen
);

  localparam longint unsigned WIDTH_MAX = (64'd1 << TIME_WIDTH) - 1;

  typedef struct packed {
    logic                      trig;
    urm5_pkg::mode_t           status;
    logic                      measured;
    logic                      timed_out;
    logic [urm5_pkg::US_W-1:0] raw_us;
    logic [urm5_pkg::MM_W-1:0] raw_mm;
    logic [urm5_pkg::US_W-1:0] measure_us;
    logic [urm5_pkg::MM_W-1:0] measure_mm;
    logic [urm5_pkg::US_W-1:0] filtered_us;
    logic [urm5_pkg::MM_W-1:0] filtered_mm;
  } reading_t;

  logic [urm5_pkg::FACTOR_W-1:0]  factor_reg;
  logic [urm5_pkg::TIMEOUT_W-1:0] timeout_reg;

  urm5_pkg::mode_t              mode;
  longint unsigned              elapsed;
  logic [urm5_pkg::DELAY_W-1:0] delay_ms;
  logic [urm5_pkg::PULSE_W-1:0] pulse_cnt;
  logic                         echo_seen;
  longint unsigned              echo_width;
  longint unsigned              last_raw;
  longint unsigned              last_measure;
  longint unsigned              history [urm5_pkg::RING_LEN];
  int                           history_idx;
  logic                         prior_echo;

  reading_t             due_readings[$];
  reading_t             want;
  int                   bad_count;
  int                   readings_checked;
  int                   timed_count;
  int                   timeout_count;

  function automatic longint unsigned ms_to_ticks(input longint unsigned ms);
    longint unsigned t;
    t = ms * TICKS_PER_MS;
    return (t > urm5_pkg::ELAPSED_MAX) ? longint'(urm5_pkg::ELAPSED_MAX) : t;
  endfunction

  function automatic longint unsigned us_to_mm(input longint unsigned us);
    longint unsigned q;
    if (factor_reg == '0) return urm5_pkg::MM_MAX;
    q = (us * urm5_pkg::MM_SCALE) / factor_reg;
    return (q > urm5_pkg::MM_MAX) ? longint'(urm5_pkg::MM_MAX) : q;
  endfunction

  function automatic longint unsigned history_median();
    longint unsigned s [urm5_pkg::RING_LEN];
    longint unsigned x;
    int              j;
    s = history;
    for (int i = 1; i < urm5_pkg::RING_LEN; i++) begin
      x = s[i];
      j = i;
      while (j > 0 && s[j-1] > x) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = x;
    end
    return s[urm5_pkg::RING_LEN/2];
  endfunction

  function automatic void bump_elapsed();
    if (elapsed < urm5_pkg::ELAPSED_MAX) elapsed++;
  endfunction

  // one microsecond tick of the ranger
  function automatic reading_t ranger_tick(input logic [urm5_pkg::OP_W-1:0] op,
                                           input logic [urm5_pkg::DELAY_W-1:0] dly,
                                           input logic echo);
    reading_t        r;
    logic            fresh;
    logic            was_waiting;
    logic            done;
    longint unsigned filt;
    r     = '0;
    fresh = 1'b0;
    done  = 1'b0;
    if (op == urm5_pkg::OP_STOP) begin
      mode = urm5_pkg::MODE_IDLE;
    end else if (op == urm5_pkg::OP_START) begin
      mode     = urm5_pkg::MODE_DELAY;
      delay_ms = dly;
      elapsed  = 0;
      fresh    = 1'b1;
    end
    was_waiting = (mode == urm5_pkg::MODE_WAIT);
    if (mode == urm5_pkg::MODE_DELAY) begin
      if (!fresh) bump_elapsed();
      if (elapsed >= ms_to_ticks(delay_ms)) begin
        mode      = urm5_pkg::MODE_PULSE;
        pulse_cnt = '0;
      end
    end
    if (mode == urm5_pkg::MODE_PULSE) begin
      r.trig    = 1'b1;
      pulse_cnt = pulse_cnt + 1'b1;
      if (pulse_cnt >= TRIGGER_HIGH_TICKS) begin
        mode       = urm5_pkg::MODE_WAIT;
        elapsed    = 0;
        echo_seen  = 1'b0;
        echo_width = 0;
      end
    end else if (was_waiting) begin
      bump_elapsed();
      if (echo_seen) begin
        if (echo) begin
          if (echo_width < WIDTH_MAX) echo_width++;
        end else begin
          done = 1'b1;
        end
      end else if (echo && !prior_echo) begin
        echo_seen  = 1'b1;
        echo_width = 1;
      end
      if (done) begin
        last_raw = echo_width;
        if (echo_width != 0) begin
          last_measure         = echo_width;
          history[history_idx] = echo_width;
          history_idx          = (history_idx + 1) % urm5_pkg::RING_LEN;
        end
        r.measured = 1'b1;
        echo_seen  = 1'b0;
        mode       = urm5_pkg::MODE_IDLE;
      end else if (elapsed >= ms_to_ticks(timeout_reg)) begin
        r.timed_out = 1'b1;
        echo_seen   = 1'b0;
        mode        = urm5_pkg::MODE_IDLE;
      end
    end
    prior_echo = echo;
    filt = history_median();
    if (filt == 0) filt = last_measure;
    r.status      = mode;
    r.raw_us      = last_raw[urm5_pkg::US_W-1:0];
    r.raw_mm      = urm5_pkg::MM_W'(us_to_mm(last_raw));
    r.measure_us  = last_measure[urm5_pkg::US_W-1:0];
    r.measure_mm  = urm5_pkg::MM_W'(us_to_mm(last_measure));
    r.filtered_us = filt[urm5_pkg::US_W-1:0];
    r.filtered_mm = urm5_pkg::MM_W'(us_to_mm(filt));
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned got_val);
    if (exp_val != got_val) begin
      bad_count++;
      if (bad_count <= 10)
        $display("reading %0d: %s expected %0d, got %0d",
                 readings_checked, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      factor_reg   = urm5_pkg::FACTOR_RESET;
      timeout_reg  = urm5_pkg::TIMEOUT_RESET;
      mode         = urm5_pkg::MODE_IDLE;
      elapsed      = 0;
      delay_ms     = '0;
      pulse_cnt    = '0;
      echo_seen    = 1'b0;
      echo_width   = 0;
      last_raw     = 0;
      last_measure = 0;
      foreach (history[i]) history[i] = 0;
      history_idx  = 0;
      prior_echo   = 1'b0;
      due_readings.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          urm5_pkg::CFG_FACTOR:  factor_reg = cfg_data;
          urm5_pkg::CFG_TIMEOUT: timeout_reg = cfg_data;
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        want = ranger_tick(tick.operation, tick.start_delay_ms, tick.echo_level);
        due_readings.push_back(want);
        if (want.measured) timed_count++;
        if (want.timed_out) timeout_count++;
      end
      if (result.valid && result.ready) begin
        if (due_readings.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("reading %0d: delivered with no tick request pending",
                     readings_checked);
        end else begin
          want = due_readings.pop_front();
          check_field("trigger_level", want.trig, result.trigger_level);
          check_field("status", want.status, result.status);
          check_field("measure_event", want.measured, result.measure_event);
          check_field("timeout_event", want.timed_out, result.timeout_event);
          check_field("raw_us", want.raw_us, result.raw_us);
          check_field("raw_mm", want.raw_mm, result.raw_mm);
          check_field("measure_us", want.measure_us, result.measure_us);
          check_field("measure_mm", want.measure_mm, result.measure_mm);
          check_field("filtered_us", want.filtered_us, result.filtered_us);
          check_field("filtered_mm", want.filtered_mm, result.filtered_mm);
        end
        readings_checked++;
      end
    end
    mismatches    <= bad_count;
    in_flight     <= due_readings.size();
    echoes_timed  <= timed_count;
    timeouts_seen <= timeout_count;
  end

  initial begin
    bad_count        = 0;
    readings_checked = 0;
    timed_count      = 0;
    timeout_count    = 0;
  end

endmodule

// ----- bench/ultrasonic_ranger_median5_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_ranger_median5_top_test
// Drives tick requests into the ranger: a short directed opening, then random
// ping sequences, broken pings and noise under several register settings with
// bursty sending and a stalling receiver. The checker predicts every reading.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_median5_top_test;

  localparam int TIME_WIDTH         = 20;
  localparam int TICKS_PER_MS       = 1000;
  localparam int TRIGGER_HIGH_TICKS = 10;

  localparam logic [urm5_pkg::OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [urm5_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  localparam int N_SETTINGS   = 7;
  localparam int RANDOM_TICKS = 1550;
  localparam int SETTLE       = 40;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_EVERY   = 20000;
  localparam int HOLD_AT      = 3000;
  localparam int LIMIT        = 2500000;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [urm5_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [urm5_pkg::CFG_DATA_W-1:0] cfg_data;

  int                    mismatches;
  int                    in_flight;
  int                    echoes_timed;
  int                    timeouts_seen;
  int                    ticks_sent = 0;
  int                    burst_left = 0;
  bit                    gaps_on = 1'b1;
  int unsigned           cycles = 0;

  urm5_tick_if   tick_ch ();
  urm5_result_if result_ch ();

  always #4 clk = ~clk;

  ultrasonic_ranger_median5_top #(
    .TIME_WIDTH        (TIME_WIDTH),
    .TICKS_PER_MS      (TICKS_PER_MS),
    .TRIGGER_HIGH_TICKS(TRIGGER_HIGH_TICKS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ultrasonic_ranger_median5_checker #(
    .TIME_WIDTH        (TIME_WIDTH),
    .TICKS_PER_MS      (TICKS_PER_MS),
    .TRIGGER_HIGH_TICKS(TRIGGER_HIGH_TICKS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick_ch),
    .result       (result_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .in_flight    (in_flight),
    .echoes_timed (echoes_timed),
    .timeouts_seen(timeouts_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: changing stall styles plus a periodic long hold-off
  initial begin
    int rx_cycles;
    int seg_left;
    int style;
    rx_cycles = 0;
    seg_left  = 0;
    style     = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles % HOLD_EVERY == HOLD_AT) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          style    = $urandom_range(0, 3);
          seg_left = $urandom_range(40, 400);
        end
        seg_left--;
        case (style)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom);
          2: result_ch.ready <= ($urandom_range(0, 4) == 0);
          default: result_ch.ready <= (rx_cycles % 7 < 3);
        endcase
      end
    end
  end

  function automatic logic [urm5_pkg::OP_W-1:0] plain_op();
    return ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_TICK;
  endfunction

  task automatic send(input logic [urm5_pkg::OP_W-1:0] op,
                      input logic [urm5_pkg::DELAY_W-1:0] dly, input logic echo);
    if (burst_left == 0) begin
      if (gaps_on) begin
        tick_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    tick_ch.valid          <= 1'b1;
    tick_ch.operation      <= op;
    tick_ch.start_delay_ms <= dly;
    tick_ch.echo_level     <= echo;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic quiet(input logic echo);
    send(plain_op(), 16'($urandom), echo);
  endtask

  task automatic drain();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [urm5_pkg::CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= urm5_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // start with no delay, trigger, then an echo of high_len ticks
  task automatic ping(input int pre_low, input int high_len, input bit high_at_wait);
    send(urm5_pkg::OP_START, 16'd0, 1'($urandom));
    for (int i = 1; i < TRIGGER_HIGH_TICKS; i++)
      quiet((i == TRIGGER_HIGH_TICKS - 1) ? high_at_wait : 1'($urandom));
    if (high_at_wait) begin
      repeat ($urandom_range(1, 3)) quiet(1'b1);
      quiet(1'b0);
    end
    repeat (pre_low) quiet(1'b0);
    repeat (high_len) quiet(1'b1);
    quiet(1'b0);
  endtask

  task automatic broken_ping();
    send(urm5_pkg::OP_START, 16'd0, 1'($urandom));
    repeat ($urandom_range(0, 30)) quiet(1'($urandom));
    case ($urandom_range(0, 2))
      0: send(urm5_pkg::OP_STOP, 16'($urandom), 1'($urandom));
      1: begin
        send(urm5_pkg::OP_START, 16'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 4)) quiet(1'($urandom));
        send(urm5_pkg::OP_STOP, 16'($urandom), 1'($urandom));
      end
      default: send(urm5_pkg::OP_START, 16'd0, 1'($urandom));
    endcase
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 12)) send(2'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // echo falls on the very tick the 1 ms timeout is reached
  task automatic echo_at_deadline();
    send(urm5_pkg::OP_START, 16'd0, 1'b0);
    repeat (TRIGGER_HIGH_TICKS - 1) quiet(1'b0);
    repeat (TICKS_PER_MS - 11) quiet(1'b0);
    repeat (10) quiet(1'b1);
    quiet(1'b0);
  endtask

  initial begin
    int factor;
    int tmo;
    int budget_end;
    int pick;
    rst                    <= 1'b1;
    tick_ch.valid          <= 1'b0;
    tick_ch.operation      <= OP_TICK;
    tick_ch.start_delay_ms <= '0;
    tick_ch.echo_level     <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= urm5_pkg::CFG_FACTOR;
    cfg_data               <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed opening at reset settings
    send(OP_SPARE, 16'hFFFF, 1'b1);
    send(urm5_pkg::OP_START, 16'd0, 1'b1);
    repeat (TRIGGER_HIGH_TICKS - 1) send(OP_TICK, 16'd0, 1'b1);
    send(OP_TICK, 16'hFFFF, 1'b1);
    send(OP_TICK, 16'd0, 1'b0);
    send(OP_TICK, 16'd0, 1'b1);
    send(OP_TICK, 16'd0, 1'b0);
    send(urm5_pkg::OP_START, 16'hFFFF, 1'b0);
    send(OP_TICK, 16'd0, 1'b1);
    send(urm5_pkg::OP_START, 16'd0, 1'b0);
    send(OP_TICK, 16'd0, 1'b0);
    send(urm5_pkg::OP_STOP, 16'd0, 1'b0);
    send(urm5_pkg::OP_START, 16'hFFFF, 1'b0);
    send(urm5_pkg::OP_STOP, 16'hFFFF, 1'b1);
    drain();

    for (int p = 0; p < N_SETTINGS; p++) begin
      case (p)
        0: begin factor = urm5_pkg::FACTOR_RESET; tmo = urm5_pkg::TIMEOUT_RESET; end
        1: begin factor = 1000; tmo = 1000; end
        2: begin factor = 400; tmo = 1; end
        3: begin factor = 0; tmo = 0; end
        4: begin factor = 1; tmo = 1023; end
        5: begin factor = 1023; tmo = 5; end
        default: begin
          factor = $urandom_range(0, 1023);
          tmo    = $urandom_range(0, 1023);
        end
      endcase
      write_reg(urm5_pkg::CFG_FACTOR, factor);
      write_reg(urm5_pkg::CFG_TIMEOUT, tmo);
      if (p == 2) begin
        send(urm5_pkg::OP_START, 16'd1, 1'b0);
        repeat (2 * TICKS_PER_MS + 30) quiet(1'b0);
        echo_at_deadline();
      end
      if (p == 4) ping(0, 2622 + $urandom_range(0, 100), 1'b0);
      budget_end = ticks_sent + RANDOM_TICKS / N_SETTINGS;
      while (ticks_sent < budget_end) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 68)
          ping($urandom_range(0, 6), $urandom_range(1, 40), $urandom_range(0, 4) == 0);
        else if (pick < 80)
          broken_ping();
        else if (pick < 92)
          noise_burst();
        else
          repeat ($urandom_range(1, 5)) quiet(1'($urandom));
        if ($urandom_range(0, 39) == 0) drain();
      end
      drain();
    end

    drain();
    $display("Ran %0d tick requests over %0d register settings:",
             ticks_sent, N_SETTINGS);
    $display("%0d echoes timed, %0d timeouts.", echoes_timed, timeouts_seen);
    if (mismatches == 0 && in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- ultrasonic_ranger_median5_top.f -----
hdl/urm5_pkg.sv
hdl/urm5_intf.sv
hdl/urm5_fifo.sv
hdl/urm5_div.sv
hdl/urm5_front.sv
hdl/urm5_back.sv
hdl/ultrasonic_ranger_median5_top.sv
bench/ultrasonic_ranger_median5_checker.sv
bench/ultrasonic_ranger_median5_top_test.sv
